// ----- rtl/snnc_pkg.sv -----
// Package with the sizes, operation codes and register indexes of the classifier.
`timescale 1ns / 1ps
`default_nettype none
package snnc_pkg;
    localparam int Entries   = 64;
    localparam int Dims      = 16;
    localparam int EntryW    = 6;
    localparam int DimW      = 4;
    localparam int LenW      = 5;
    localparam int FeatAddrW = EntryW + DimW;

    localparam logic [1:0] OP_SCALE   = 2'd0;
    localparam logic [1:0] OP_FEATURE = 2'd1;
    localparam logic [1:0] OP_HEADER  = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [0:0] REG_THRESHOLD = 1'd0;
    localparam logic [0:0] REG_ENABLE    = 1'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  entry;
        logic [3:0]  dim;
        logic [31:0] value;
        logic [31:0] scale;
        logic [7:0]  label;
        logic [4:0]  length;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  label_res;
        logic        unknown;
        logic        found;
        logic [63:0] distance;
    } t_out_item;
endpackage
`default_nettype wire

// ----- rtl/snnc_if.sv -----
// Channel interfaces of the classifier: request channels and the register write channel.
`timescale 1ns / 1ps
`default_nettype none
interface snnc_in_if;
    logic valid;
    logic ready;
    snnc_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface snnc_out_if;
    logic valid;
    logic ready;
    snnc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface snnc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/scaled_nearest_neighbor_classifier.sv -----
// Top level of the scaled nearest-neighbour classifier with its search sequencer.
// Scale, feature and header writes and non-final query elements are taken in the idle state.
// A final query element starts a walk of all 64 entries: an entry that is empty or of another
// length is skipped after its header read, and a matching one is read, divided, multiplied and
// accumulated per dimension. Synchronous active-low reset clears header valid bits, scales,
// query count, enable register and result valid, and sets the threshold register to all ones.
`timescale 1ns / 1ps
`default_nettype none
module scaled_nearest_neighbor_classifier (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    snnc_in_if.sink       i_req,
    snnc_out_if.source    o_res,
    snnc_cfg_if.sink      i_cfg
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_ENTRY, S_READ, S_DIV, S_MUL, S_ACC, S_NEXT, S_OUT
    } t_state;

    t_state r_state;

    // Storage. The feature, label and length stores are memories with registered reads.
    // A header valid bit per entry makes entries read as empty until their header is written.
    logic [31:0] r_feat_mem [snnc_pkg::Entries * snnc_pkg::Dims];
    logic [31:0] r_feat_rd;
    logic [31:0] r_scale [snnc_pkg::Dims];
    logic [7:0]  r_label [snnc_pkg::Entries];
    logic [7:0]  r_label_rd;
    logic [snnc_pkg::LenW-1:0] r_len [snnc_pkg::Entries];
    logic [snnc_pkg::LenW-1:0] r_len_rd;
    logic [snnc_pkg::Entries-1:0] r_hdr_ok;
    logic [31:0] r_query [snnc_pkg::Dims];
    logic [snnc_pkg::LenW-1:0] r_qcount;

    logic [63:0] r_threshold;
    logic        r_enable;

    // Search state.
    logic [snnc_pkg::EntryW:0] r_ent;
    logic [snnc_pkg::DimW:0]   r_dim;
    logic [63:0] r_sum;
    logic [63:0] r_best;
    logic [7:0]  r_best_label;
    logic        r_found;

    // Shared serial divider: dividend (mag << 16), 49 bits, divisor 32 bits.
    // All 49 quotient bits are developed; the low 33 are kept and any one bit
    // shifted out above them is remembered, since it forces saturation.
    logic [48:0] r_dividend;
    logic [32:0] r_rem;
    logic [32:0] r_quot;
    logic        r_qovf;
    logic [31:0] r_divisor;
    logic [5:0]  r_step;
    logic [63:0] r_term;

    snnc_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic in_fire;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign in_fire     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    snnc_pkg::t_in_item req;
    assign req = i_req.data;

    // Difference and magnitude of the current query element and feature.
    logic signed [32:0] diff;
    logic [32:0] mag;
    logic [31:0] cur_q;
    logic [31:0] cur_scale;
    assign cur_q     = r_query[r_dim[snnc_pkg::DimW-1:0]];
    assign cur_scale = r_scale[r_dim[snnc_pkg::DimW-1:0]];
    assign diff = 33'(signed'(cur_q)) - 33'(signed'(r_feat_rd));
    assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

    // One restoring divide step.
    logic [33:0] trial;
    logic [32:0] rem_sh;
    assign rem_sh = {r_rem[31:0], r_dividend[48]};
    assign trial  = {1'b0, rem_sh} - {2'b0, r_divisor};

    // Saturated quotient, Q16.16.
    logic [31:0] qsat;
    assign qsat = (r_qovf || r_quot[32]) ? 32'hFFFF_FFFF : r_quot[31:0];

    logic [64:0] sum_wide;
    assign sum_wide = {1'b0, r_sum} + {1'b0, r_term};

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (in_fire && req.op == snnc_pkg::OP_FEATURE) begin
            r_feat_mem[{req.entry, req.dim}] <= req.value;
        end
        r_feat_rd <= r_feat_mem[{r_ent[snnc_pkg::EntryW-1:0], r_dim[snnc_pkg::DimW-1:0]}];
        if (in_fire && req.op == snnc_pkg::OP_HEADER) begin
            r_label[req.entry] <= req.label;
            r_len[req.entry]   <= (req.length > 5'(snnc_pkg::Dims))
                                  ? 5'(snnc_pkg::Dims) : req.length;
        end
        r_label_rd <= r_label[r_ent[snnc_pkg::EntryW-1:0]];
        r_len_rd   <= r_hdr_ok[r_ent[snnc_pkg::EntryW-1:0]]
                      ? r_len[r_ent[snnc_pkg::EntryW-1:0]] : '0;
        if (in_fire && req.op == snnc_pkg::OP_QUERY && r_qcount < 5'(snnc_pkg::Dims)) begin
            r_query[r_qcount[snnc_pkg::DimW-1:0]] <= req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qcount    <= '0;
            r_threshold <= '1;
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
            r_hdr_ok    <= '0;
            for (int i = 0; i < snnc_pkg::Dims; i++) r_scale[i] <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    snnc_pkg::REG_THRESHOLD: r_threshold <= i_cfg.wdata;
                    snnc_pkg::REG_ENABLE:    r_enable    <= i_cfg.wdata[0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_res.ready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (req.op)
                            snnc_pkg::OP_SCALE: r_scale[req.dim] <= req.scale;
                            snnc_pkg::OP_HEADER: r_hdr_ok[req.entry] <= 1'b1;
                            snnc_pkg::OP_QUERY: begin
                                if (r_qcount < 5'(snnc_pkg::Dims)) r_qcount <= r_qcount + 5'd1;
                                if (req.last) begin
                                    r_ent        <= '0;
                                    r_found      <= 1'b0;
                                    r_best       <= '1;
                                    r_best_label <= '0;
                                    r_state      <= S_LOOK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOOK: begin
                    // Header read of the current entry in flight.
                    if (r_ent == 7'(snnc_pkg::Entries)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ENTRY;
                    end
                end
                S_ENTRY: begin
                    // Skip entries that are empty or of another length.
                    if (r_len_rd == '0 || r_len_rd != r_qcount) begin
                        r_ent   <= r_ent + 7'd1;
                        r_state <= S_LOOK;
                    end else begin
                        r_dim   <= '0;
                        r_sum   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // Memory read in flight; load the divider next.
                    r_state <= S_DIV;
                    r_step  <= '0;
                end
                S_DIV: begin
                    if (r_step == 6'd0) begin
                        r_dividend <= {mag[32:0], 16'b0};
                        r_divisor  <= (cur_scale == '0) ? 32'h0001_0000 : cur_scale;
                        r_rem      <= '0;
                        r_quot     <= '0;
                        r_qovf     <= 1'b0;
                        r_step     <= 6'd1;
                    end else begin
                        r_dividend <= {r_dividend[47:0], 1'b0};
                        r_qovf     <= r_qovf | r_quot[32];
                        if (!trial[33]) begin
                            r_rem  <= trial[32:0];
                            r_quot <= {r_quot[31:0], 1'b1};
                        end else begin
                            r_rem  <= rem_sh;
                            r_quot <= {r_quot[31:0], 1'b0};
                        end
                        if (r_step == 6'd49) r_state <= S_MUL;
                        r_step <= r_step + 6'd1;
                    end
                end
                S_MUL: begin
                    r_term  <= 64'(qsat) * 64'(qsat);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= sum_wide[64] ? '1 : sum_wide[63:0];
                    if (5'(r_dim) + 5'd1 == r_qcount) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dim   <= r_dim + 5'd1;
                        r_state <= S_READ;
                    end
                end
                S_NEXT: begin
                    if (!r_found || r_sum < r_best) begin
                        r_best       <= r_sum;
                        r_best_label <= r_label_rd;
                    end
                    r_found <= 1'b1;
                    r_ent   <= r_ent + 7'd1;
                    r_state <= S_LOOK;
                end
                S_OUT: begin
                    logic unk;
                    unk = !r_found || (r_enable && r_best > r_threshold);
                    r_out.label_res <= unk ? 8'd0 : r_best_label;
                    r_out.unknown   <= unk;
                    r_out.found     <= r_found;
                    r_out.distance  <= r_best;
                    r_out_valid     <= 1'b1;
                    r_qcount        <= '0;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/snnc_checker.sv -----
// Port-level checker of the classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module snnc_port_props (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic o_res_valid,
    input wire logic o_res_ready,
    input wire logic o_unknown,
    input wire logic o_found,
    input wire logic [7:0] o_label,
    input wire logic [63:0] o_distance
);
    // A waiting result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_ready |=> o_res_valid && $stable(o_distance))
        else $error("result dropped while stalled");
    // Nothing found means unknown with maximum distance.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_found |-> o_unknown && (o_distance == '1))
        else $error("no-match result malformed");
    // An unknown result carries label zero.
    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_unknown |-> o_label == 8'd0)
        else $error("unknown result carries a label");
    // No request is taken while a result waits.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !i_req_ready)
        else $error("request accepted while result pending");
endmodule

bind scaled_nearest_neighbor_classifier snnc_port_props u_snnc_port_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_res_valid (o_res.valid),
    .o_res_ready (o_res.ready),
    .o_unknown   (o_res.data.unknown),
    .o_found     (o_res.data.found),
    .o_label     (o_res.data.label_res),
    .o_distance  (o_res.data.distance)
);
`default_nettype wire

// ----- verif/snnc_checker.sv -----
// Checker that predicts the classifier's answers from the observed requests and compares them.
`timescale 1ns / 1ps
`default_nettype none
module snnc_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    snnc_in_if        req_ch,
    snnc_out_if       res_ch,
    snnc_cfg_if       cfg_ch,
    output int        o_errors,
    output int        o_pending,
    output int        o_answers
);
    logic [31:0] feat_mem [snnc_pkg::Entries*snnc_pkg::Dims];
    logic [31:0] scale_mem [snnc_pkg::Dims];
    logic [7:0]  label_mem [snnc_pkg::Entries];
    logic [4:0]  len_mem [snnc_pkg::Entries];
    logic [31:0] qbuf [snnc_pkg::Dims];
    logic [4:0]  qcount;
    logic [63:0] threshold;
    logic        rej_en;
    snnc_pkg::t_out_item answer_q [$];

    // Squared scaled difference of one dimension, Q32.32.
    function automatic logic [63:0] sq_term(logic [31:0] q, logic [31:0] f, logic [31:0] s);
        logic signed [32:0] d;
        logic [32:0] mag;
        logic [48:0] quo;
        logic [63:0] qs;
        d = $signed({q[31], q}) - $signed({f[31], f});
        mag = (d < 0) ? 33'(-d) : 33'(d);
        quo = {mag, 16'b0} / ((s == 0) ? 49'd65536 : 49'(s));
        qs = (quo > 49'hFFFF_FFFF) ? 64'hFFFF_FFFF : 64'(quo);
        return qs * qs;
    endfunction

    function automatic snnc_pkg::t_out_item classify();
        snnc_pkg::t_out_item r;
        logic [63:0] best;
        logic [63:0] sum;
        logic [64:0] acc;
        logic        hit;
        logic [7:0]  lab;
        best = '1;
        hit = 1'b0;
        lab = '0;
        for (int e = 0; e < snnc_pkg::Entries; e++) begin
            if (len_mem[e] != 0 && len_mem[e] == qcount) begin
                sum = '0;
                for (int i = 0; i < qcount; i++) begin
                    acc = {1'b0, sum} + sq_term(qbuf[i], feat_mem[e*snnc_pkg::Dims+i],
                                                scale_mem[i]);
                    sum = acc[64] ? '1 : acc[63:0];
                end
                // The first match is always taken; later ones only when strictly nearer.
                if (!hit || sum < best) begin
                    best = sum;
                    lab = label_mem[e];
                end
                hit = 1'b1;
            end
        end
        r.unknown = !hit || (rej_en && best > threshold);
        r.label_res = r.unknown ? 8'd0 : lab;
        r.found = hit;
        r.distance = best;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_answers = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        snnc_pkg::t_in_item it;
        snnc_pkg::t_out_item got;
        snnc_pkg::t_out_item want;
        if (!i_rst_n) begin
            foreach (scale_mem[i]) scale_mem[i] = '0;
            foreach (len_mem[i]) len_mem[i] = '0;
            qcount = '0;
            threshold = '1;
            rej_en = 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == snnc_pkg::REG_THRESHOLD) threshold = cfg_ch.wdata;
                else if (cfg_ch.index == snnc_pkg::REG_ENABLE) rej_en = cfg_ch.wdata[0];
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                o_answers++;
                if (answer_q.size() == 0) begin
                    report("unexpected answer", got.distance, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (got.label_res != want.label_res)
                        report("label", got.label_res, want.label_res);
                    if (got.unknown != want.unknown) report("unknown", got.unknown, want.unknown);
                    if (got.found != want.found) report("found", got.found, want.found);
                    if (got.distance != want.distance)
                        report("distance", got.distance, want.distance);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                it = req_ch.data;
                case (it.op)
                    snnc_pkg::OP_SCALE: scale_mem[it.dim] = it.scale;
                    snnc_pkg::OP_FEATURE: feat_mem[it.entry*snnc_pkg::Dims+it.dim] = it.value;
                    snnc_pkg::OP_HEADER: begin
                        label_mem[it.entry] = it.label;
                        len_mem[it.entry] = (it.length > snnc_pkg::Dims)
                                            ? snnc_pkg::LenW'(snnc_pkg::Dims) : it.length;
                    end
                    snnc_pkg::OP_QUERY: begin
                        if (qcount < snnc_pkg::Dims) begin
                            qbuf[qcount] = it.value;
                            qcount++;
                        end
                        if (it.last) begin
                            answer_q = {answer_q, classify()};
                            qcount = '0;
                        end
                    end
                endcase
            end
        end
        o_pending = answer_q.size();
    end
endmodule
`default_nettype wire

// ----- verif/scaled_nearest_neighbor_classifier_tb.sv -----
// Top of the classifier testbench: clock, reset, request stimulus, idling and verdict.
`timescale 1ns / 1ps
`default_nettype none
module scaled_nearest_neighbor_classifier_tb;
    logic i_clk = 1'b0;
    logic i_rst_n;

    snnc_in_if  req_ch ();
    snnc_out_if res_ch ();
    snnc_cfg_if cfg_ch ();

    int errors;
    int pending;
    int answers;
    int sent;
    int tx_pct;
    int rx_pct;
    logic hold_rx;

    // Our own view of what has been loaded, so that stimulus can aim queries at real entries
    // and never make the block read a feature that was never written.
    logic [31:0] feat_copy [snnc_pkg::Entries][snnc_pkg::Dims];
    logic [15:0] feat_written [snnc_pkg::Entries];
    logic [4:0]  len_copy [snnc_pkg::Entries];

    scaled_nearest_neighbor_classifier DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    snnc_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req_ch   (req_ch),
        .res_ch   (res_ch),
        .cfg_ch   (cfg_ch),
        .o_errors (errors),
        .o_pending(pending),
        .o_answers(answers)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The receiver stalls at random unless a long hold-off is in force.
    always @(posedge i_clk) begin
        res_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= rx_pct);
    end

    // Sends one request and waits for it to be taken, then perhaps idles for a while.
    task automatic send_req(input snnc_pkg::t_in_item it);
        req_ch.data <= it;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
        if ($urandom_range(0, 99) < tx_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_pct);
        end
    endtask

    function automatic snnc_pkg::t_in_item noise_item();
        snnc_pkg::t_in_item it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(snnc_pkg::t_in_item)-1:0];
        return it;
    endfunction

    task automatic write_scale(input int d, input logic [31:0] s);
        snnc_pkg::t_in_item it;
        it = noise_item();
        it.op = snnc_pkg::OP_SCALE;
        it.dim = snnc_pkg::DimW'(d);
        it.scale = s;
        send_req(it);
    endtask

    task automatic write_feature(input int e, input int d, input logic [31:0] v);
        snnc_pkg::t_in_item it;
        it = noise_item();
        it.op = snnc_pkg::OP_FEATURE;
        it.entry = snnc_pkg::EntryW'(e);
        it.dim = snnc_pkg::DimW'(d);
        it.value = v;
        send_req(it);
        feat_copy[e][d] = v;
        feat_written[e][d] = 1'b1;
    endtask

    // A header write is only issued once every feature it brings into use has been written.
    task automatic write_header(input int e, input logic [7:0] lab, input logic [4:0] len);
        snnc_pkg::t_in_item it;
        it = noise_item();
        it.op = snnc_pkg::OP_HEADER;
        it.entry = snnc_pkg::EntryW'(e);
        it.label = lab;
        it.length = len;
        send_req(it);
        len_copy[e] = (len > snnc_pkg::Dims) ? snnc_pkg::LenW'(snnc_pkg::Dims) : len;
    endtask

    task automatic load_entry(input int e, input logic [7:0] lab, input int len);
        int n;
        n = (len > snnc_pkg::Dims) ? snnc_pkg::Dims : len;
        for (int d = 0; d < n; d++) write_feature(e, d, $urandom);
        write_header(e, lab, 5'(len));
    endtask

    // A query of len elements; near >= 0 aims the elements close to that entry.
    task automatic query(input int len, input int near);
        snnc_pkg::t_in_item it;
        for (int i = 0; i < len; i++) begin
            it = noise_item();
            it.op = snnc_pkg::OP_QUERY;
            it.last = (i == len - 1);
            if (near >= 0 && i < snnc_pkg::Dims && $urandom_range(0, 3) != 0)
                it.value = feat_copy[near][i] + $urandom_range(0, 1 << 18) - (1 << 17);
            send_req(it);
        end
    endtask

    task automatic drop_valid();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected answer is in, then lets the last writes settle.
    task automatic wait_idle();
        drop_valid();
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] v);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_traffic(input int count);
        int goal;
        int e;
        int r;
        goal = sent + count;
        while (sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                // Well-formed query aimed at a loaded entry, or a query of random length.
                e = $urandom_range(0, 15);
                if (len_copy[e] != 0 && r < 55) query(len_copy[e], e);
                else query($urandom_range(1, 19), -1);
            end else if (r < 80) begin
                e = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 63) : $urandom_range(0, 15);
                load_entry(e, 8'($urandom),
                           (e > 15) ? $urandom_range(1, 3) : $urandom_range(0, 16));
            end else if (r < 88) begin
                case ($urandom_range(0, 3))
                    0: write_scale($urandom_range(0, 15), 32'd0);
                    1: write_scale($urandom_range(0, 15), $urandom);
                    default: write_scale($urandom_range(0, 15), $urandom_range(1 << 12, 1 << 20));
                endcase
            end else if (r < 95) begin
                write_feature($urandom_range(0, 63), $urandom_range(0, 15), $urandom);
            end else begin
                // Header rewrite within what is already written; lengths above the table
                // width are allowed once all sixteen features exist.
                e = $urandom_range(0, 15);
                if (&feat_written[e]) write_header(e, 8'($urandom), 5'($urandom_range(0, 31)));
                else write_header(e, 8'($urandom), 5'd0);
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_pct = 0;  rx_pct = 0;  end
            1: begin tx_pct = 83; rx_pct = 0;  end
            2: begin tx_pct = 0;  rx_pct = 83; end
            default: begin tx_pct = 12; rx_pct = 12; end
        endcase
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.wdata <= '0;
        hold_rx = 1'b0;
        sent = 0;
        set_idling(0);
        foreach (feat_written[e]) begin
            feat_written[e] = '0;
            len_copy[e] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A query on the empty table finds nothing.
        query(2, -1);
        // Scale extremes: zero (taken as one), the smallest step and the largest.
        write_scale(0, 32'd0);
        write_scale(1, 32'd1);
        write_scale(2, 32'hFFFF_FFFF);
        // Opposite feature extremes so that the quotient saturates.
        write_feature(0, 0, 32'h8000_0000);
        write_feature(0, 1, 32'h7FFF_FFFF);
        write_header(0, 8'hFF, 5'd2);
        // A twin entry with the same features ties; the lower index must win.
        write_feature(1, 0, 32'h8000_0000);
        write_feature(1, 1, 32'h7FFF_FFFF);
        write_header(1, 8'h01, 5'd2);
        query(2, -1);
        query(2, 0);
        // A header with length above the table width is clamped; a long query is cut.
        load_entry(2, 8'h5A, 31);
        query(18, 2);
        // Emptying an entry takes it out of the search.
        write_header(1, 8'h00, 5'd0);
        query(2, 0);
        wait_idle();

        // Random phases through several register settings and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(snnc_pkg::REG_THRESHOLD, '1);
                         write_reg(snnc_pkg::REG_ENABLE, 64'd0); end
                1: begin write_reg(snnc_pkg::REG_THRESHOLD, '0);
                         write_reg(snnc_pkg::REG_ENABLE, 64'd1); end
                2: begin write_reg(snnc_pkg::REG_THRESHOLD, {$urandom_range(0, 64), $urandom});
                         write_reg(snnc_pkg::REG_ENABLE, 64'd1); end
                3: begin write_reg(snnc_pkg::REG_THRESHOLD, '1);
                         write_reg(snnc_pkg::REG_ENABLE, 64'd1); end
                4: begin write_reg(snnc_pkg::REG_THRESHOLD, {$urandom, $urandom});
                         write_reg(snnc_pkg::REG_ENABLE, 64'd1); end
                default: begin write_reg(snnc_pkg::REG_THRESHOLD, {$urandom_range(0, 8), $urandom});
                         write_reg(snnc_pkg::REG_ENABLE, 64'd0); end
            endcase
            set_idling(ph % 4);
            if (ph == 2) begin
                // Long receiver hold-off while short queries keep coming, so the block backs up.
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
                for (int k = 0; k < 30; k++) query(1, -1);
            end
            random_traffic(130);
            wait_idle();
        end

        $display("Covered %0d requests and %0d classifications over six register settings,",
                 sent, answers);
        $display("with empty, tied, saturated, clamped and rejected searches and idle patterns.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5s;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
